>>> rtl/swcb_pkg.sv
`default_nettype none

package swcb_pkg;

  // ring depth default
  localparam int RING_BUCKETS_DEF = 64;

  // field and register widths
  localparam int REQ_W      = 2;
  localparam int TIME_W     = 32;
  localparam int MODE_W     = 2;
  localparam int WIN_W      = 6;
  localparam int TRIP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BUCKET_W   = 16;

  localparam logic [BUCKET_W-1:0] BUCKET_MAX = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SUCCESS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FAILURE = 2'd2;

  // breaker modes
  localparam logic [MODE_W-1:0] MODE_CLOSED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_FAILURES  = 2'd1;

  // configuration reset values
  localparam logic [WIN_W-1:0]  WINDOW_SECONDS_RST = 6'd10;
  localparam logic [TRIP_W-1:0] TRIP_FAILURES_RST  = 16'd20;

  // half-open limits
  localparam int HALF_FAIL_LIMIT = 5;
  localparam int HALF_SUCC_LIMIT = 10;

endpackage

`default_nettype wire

>>> rtl/sliding_window_circuit_breaker_unit.sv
// Sliding-window circuit breaker. Each request carries a type (check, success report,
// failure report) and the time in seconds; the unit keeps a ring of RING_BUCKETS
// one-second buckets of success and failure counts in a single-port-write memory, plus
// running totals, and answers every request with one result (allowed, mode). Requests
// are handled one at a time by a small sequencer around one shared 32-bit subtractor:
// it takes the gap to the window start, decides on expiry, computes the expiry count and
// for each expired bucket reads the memory and subtracts it from the totals; then it forms
// the current bucket index, brings it back into the ring by ring-size subtraction (at most
// one unless RING_BUCKETS is below the window length), takes the gap to the last update,
// steps the mode, reads and writes the bucket and loads the result register. A request
// is accepted only in the idle state, never before the last one is finished, and a result
// still stalled in the output register holds the sequencer in its last state. A full
// clear only resets the per-bucket valid bits, so there is no clearing pass after reset.
// in_stall is high while a request is in progress; a finished result waits in the output
// register while the next request is taken. Configuration writes are always accepted
// (cfg_ready high) and must only be issued while the unit is idle.
`default_nettype none

module sliding_window_circuit_breaker_unit #(
  parameter int RING_BUCKETS = swcb_pkg::RING_BUCKETS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [swcb_pkg::REQ_W-1:0]      req_type,
  input  wire logic [swcb_pkg::TIME_W-1:0]     now_seconds,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 allowed,
  output logic [swcb_pkg::MODE_W-1:0]          mode,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [swcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swcb_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ring index, expiry count, wrap-sum and total widths
  localparam int IW = $clog2(RING_BUCKETS);
  localparam int CW = IW + 1;
  localparam int SW = ((IW > swcb_pkg::WIN_W) ? IW : swcb_pkg::WIN_W) + 1;
  localparam int TW = swcb_pkg::BUCKET_W + IW;
  localparam int BW = swcb_pkg::BUCKET_W;
  localparam int TMW = swcb_pkg::TIME_W;

  localparam logic [TMW-1:0]  RING_T    = TMW'(RING_BUCKETS);
  localparam logic [SW-1:0]   RING_S    = SW'(RING_BUCKETS);
  localparam logic [IW-1:0]   LAST_IDX  = IW'(RING_BUCKETS - 1);
  localparam logic [TW-1:0]   HALF_FAIL = TW'(swcb_pkg::HALF_FAIL_LIMIT);
  localparam logic [TW-1:0]   HALF_SUCC = TW'(swcb_pkg::HALF_SUCC_LIMIT);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GAP  = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_ADV  = 4'd3;
  localparam logic [3:0] S_XRD  = 4'd4;
  localparam logic [3:0] S_XSUB = 4'd5;
  localparam logic [3:0] S_CUR  = 4'd6;
  localparam logic [3:0] S_WRAP = 4'd7;
  localparam logic [3:0] S_LUT  = 4'd8;
  localparam logic [3:0] S_MODE = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state;

  // configuration
  logic [swcb_pkg::WIN_W-1:0]  window_seconds;
  logic [swcb_pkg::TRIP_W-1:0] trip_failures;

  // latched request
  logic [swcb_pkg::REQ_W-1:0] req_q;
  logic [TMW-1:0]             now_q;

  // breaker state
  logic [TW-1:0]              window_failures;
  logic [TW-1:0]              window_successes;
  logic [IW-1:0]              oldest_bucket;
  logic [IW-1:0]              current_bucket;
  logic [TMW-1:0]             window_start_time;
  logic [TMW-1:0]             last_update_time;
  logic [swcb_pkg::MODE_W-1:0] breaker_mode;

  // sequencer working registers
  logic [TMW-1:0] gap_q;
  logic [TMW-1:0] lgap_q;
  logic           lborrow_q;
  logic [CW-1:0]  cnt;
  logic [SW-1:0]  sum_q;

  // bucket memory: {failures, successes}, valid bit per bucket
  logic [2*BW-1:0]         mem [RING_BUCKETS];
  logic [RING_BUCKETS-1:0] vld;
  logic [2*BW-1:0]         rd_data;
  logic                    rd_vld;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [IW-1:0]           mem_raddr;
  logic [2*BW-1:0]         mem_wdata;

  // shared subtractor
  logic [TMW-1:0] su_a;
  logic [TMW-1:0] su_b;
  logic [TMW:0]   su_diff;

  logic [TMW-1:0] win_t;
  logic [TMW-1:0] win3_t;
  logic           mode_hold;
  logic           clr;
  logic [swcb_pkg::MODE_W-1:0] clr_mode;

  logic [BW-1:0] cur_s;
  logic [BW-1:0] cur_f;
  logic          inc_s;
  logic          inc_f;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign win_t  = TMW'(window_seconds);
  assign win3_t = TMW'({window_seconds, 1'b0}) + win_t;

  // operand selection for the one subtractor
  always_comb begin
    su_a = now_q;
    su_b = window_start_time;
    unique case (state)
      S_ADV: begin
        // adv = gap - (w - 1); w is nonzero on this path
        su_a = gap_q;
        su_b = TMW'(window_seconds - swcb_pkg::WIN_W'(1));
      end
      S_LUT: begin
        su_b = last_update_time;
      end
      default: begin
        su_a = now_q;
        su_b = window_start_time;
      end
    endcase
    su_diff = {1'b0, su_a} - {1'b0, su_b};
  end

  // open hold: time went back, or still inside the window since the last update
  assign mode_hold = (breaker_mode == swcb_pkg::MODE_OPEN) &&
                     (lborrow_q || (lgap_q <= win_t));

  // full clear requests and the mode they leave behind
  always_comb begin
    clr      = 1'b0;
    clr_mode = swcb_pkg::MODE_CLOSED;
    unique case (state)
      S_GAP: begin
        // time went backwards past the window start
        clr = su_diff[TMW];
      end
      S_DEC: begin
        // gap of three windows or the whole ring
        clr = (gap_q >= win_t) && ((gap_q >= win3_t) || (gap_q >= RING_T));
      end
      S_MODE: begin
        if (!mode_hold) begin
          priority if (breaker_mode == swcb_pkg::MODE_CLOSED) begin
            clr      = (window_failures >= TW'(trip_failures));
            clr_mode = swcb_pkg::MODE_OPEN;
          end else if (breaker_mode == swcb_pkg::MODE_HALF) begin
            if (window_failures > HALF_FAIL) begin
              clr      = 1'b1;
              clr_mode = swcb_pkg::MODE_OPEN;
            end else if (window_successes > HALF_SUCC) begin
              clr      = 1'b1;
              clr_mode = swcb_pkg::MODE_CLOSED;
            end
          end else begin
            // open hold is over
            clr      = 1'b1;
            clr_mode = swcb_pkg::MODE_HALF;
          end
        end
      end
      default: begin
        clr = 1'b0;
      end
    endcase
  end

  // bucket update for the report, counts saturate
  assign cur_s = rd_vld ? rd_data[BW-1:0] : '0;
  assign cur_f = rd_vld ? rd_data[2*BW-1:BW] : '0;
  assign inc_s = (req_q == swcb_pkg::REQ_SUCCESS) && (cur_s != swcb_pkg::BUCKET_MAX);
  assign inc_f = (req_q == swcb_pkg::REQ_FAILURE) && (cur_f != swcb_pkg::BUCKET_MAX);

  assign mem_we    = (state == S_WR) && (inc_s || inc_f);
  assign mem_waddr = current_bucket;
  assign mem_wdata = {(inc_f ? cur_f + BW'(1) : cur_f), (inc_s ? cur_s + BW'(1) : cur_s)};
  assign mem_raddr = (state == S_XRD) ? oldest_bucket : current_bucket;

  // bucket memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      window_seconds    <= swcb_pkg::WINDOW_SECONDS_RST;
      trip_failures     <= swcb_pkg::TRIP_FAILURES_RST;
      window_failures   <= '0;
      window_successes  <= '0;
      oldest_bucket     <= '0;
      current_bucket    <= '0;
      window_start_time <= '0;
      last_update_time  <= '0;
      breaker_mode      <= swcb_pkg::MODE_CLOSED;
      vld               <= '0;
      rd_vld            <= 1'b0;
      cnt               <= '0;
      out_valid         <= 1'b0;
    end else begin
      rd_vld <= vld[mem_raddr];

      // result taken; a new one loaded in S_OUT replaces it there
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          swcb_pkg::CFG_WINDOW_SECONDS: window_seconds <= cfg_data[swcb_pkg::WIN_W-1:0];
          swcb_pkg::CFG_TRIP_FAILURES:  trip_failures  <= cfg_data[swcb_pkg::TRIP_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_type;
            now_q <= now_seconds;
            state <= S_GAP;
          end
        end
        S_GAP: begin
          // after a clear the window starts now
          gap_q <= su_diff[TMW] ? '0 : su_diff[TMW-1:0];
          state <= S_DEC;
        end
        S_DEC: begin
          if ((gap_q < win_t) || clr) begin
            state <= S_CUR;
          end else begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          // gap is below the ring size here, so the count fits
          cnt   <= su_diff[CW-1:0];
          state <= S_XRD;
        end
        S_XRD: begin
          state <= S_XSUB;
        end
        S_XSUB: begin
          // expire the oldest bucket
          if (rd_vld) begin
            window_failures  <= window_failures - TW'(rd_data[2*BW-1:BW]);
            window_successes <= window_successes - TW'(rd_data[BW-1:0]);
          end
          vld[oldest_bucket] <= 1'b0;
          oldest_bucket      <= (oldest_bucket == LAST_IDX) ? '0 : oldest_bucket + IW'(1);
          window_start_time  <= window_start_time + TMW'(1);
          cnt                <= cnt - CW'(1);
          state              <= (cnt == CW'(1)) ? S_CUR : S_XRD;
        end
        S_CUR: begin
          // offset from the window start is below the window length
          sum_q <= SW'(oldest_bucket) + SW'(su_diff[swcb_pkg::WIN_W-1:0]);
          state <= S_WRAP;
        end
        S_WRAP: begin
          // reduce modulo the ring size, one subtraction per cycle
          if (sum_q >= RING_S) begin
            sum_q <= sum_q - RING_S;
          end else begin
            state <= S_LUT;
          end
        end
        S_LUT: begin
          lgap_q    <= su_diff[TMW-1:0];
          lborrow_q <= su_diff[TMW];
          state     <= S_MODE;
        end
        S_MODE: begin
          // a mode change below sets both itself
          if (!mode_hold && !clr) begin
            last_update_time <= now_q;
            current_bucket   <= sum_q[IW-1:0];
          end
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (inc_s) begin
            window_successes <= window_successes + TW'(1);
          end
          if (inc_f) begin
            window_failures <= window_failures + TW'(1);
          end
          if (mem_we) begin
            vld[current_bucket] <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // result register free or draining this cycle
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            allowed   <= (breaker_mode != swcb_pkg::MODE_OPEN);
            mode      <= breaker_mode;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // full clear, also on a mode change
      if (clr) begin
        vld               <= '0;
        window_failures   <= '0;
        window_successes  <= '0;
        oldest_bucket     <= '0;
        current_bucket    <= '0;
        window_start_time <= now_q;
        last_update_time  <= now_q;
        breaker_mode      <= clr_mode;
      end
    end
  end

  // result fields agree with each other
  a_allowed_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (allowed == (mode != swcb_pkg::MODE_OPEN)))
    else $error("allowed disagrees with mode");

  // expiry never runs with an empty count
  a_expire_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_XSUB) |-> (cnt != '0))
    else $error("bucket expiry with zero count");

  // a full clear leaves empty totals and the ring at its start
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clr |=> ((window_failures == '0) && (window_successes == '0) &&
             (oldest_bucket == '0) && (vld == '0)))
    else $error("full clear left state behind");

  // ring pointers stay inside the ring
  a_oldest_range: assert property (@(posedge clk) disable iff (rst)
    (oldest_bucket <= LAST_IDX) && (current_bucket <= LAST_IDX))
    else $error("bucket index outside the ring");

endmodule

`default_nettype wire

>>> sim/sliding_window_circuit_breaker_unit_test.sv
`timescale 1ns / 1ps

module sliding_window_circuit_breaker_unit_test;
  import swcb_pkg::*;

  // request code that the block treats as a plain check
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RING = RING_BUCKETS_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 238;

  // request mix used by a burst of random requests
  localparam int MIX_EVEN    = 0;
  localparam int MIX_FAILS   = 1;
  localparam int MIX_SUCCESS = 2;
  localparam int MIX_CHECKS  = 3;

  typedef struct packed {
    logic              allowed;
    logic [MODE_W-1:0] mode;
  } verdict_t;

  // breaker predictor plus the queue of verdicts it has promised
  class breaker_tracker;
    logic [BUCKET_W-1:0] succ_cnt [RING];
    logic [BUCKET_W-1:0] fail_cnt [RING];
    logic [21:0]         win_succ;
    logic [21:0]         win_fail;
    int unsigned         oldest;
    int unsigned         cur;
    logic [TIME_W-1:0]   win_start;
    logic [TIME_W-1:0]   last_upd;
    logic [MODE_W-1:0]   brk_mode;
    logic [WIN_W-1:0]    win_len;
    logic [TRIP_W-1:0]   trip_lvl;
    verdict_t            verdicts[$];
    int unsigned         errors;
    int unsigned         noted;
    int unsigned         mode_hits [4];

    function new();
      win_len  = WINDOW_SECONDS_RST;
      trip_lvl = TRIP_FAILURES_RST;
      errors   = 0;
      noted    = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      wipe('0);
    endfunction

    function void wipe(logic [TIME_W-1:0] now);
      foreach (succ_cnt[i]) begin
        succ_cnt[i] = '0;
        fail_cnt[i] = '0;
      end
      win_succ  = '0;
      win_fail  = '0;
      brk_mode  = MODE_CLOSED;
      oldest    = 0;
      cur       = 0;
      win_start = now;
      last_upd  = now;
    endfunction

    function void enter_mode(logic [TIME_W-1:0] now, logic [MODE_W-1:0] m);
      wipe(now);
      brk_mode = m;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WINDOW_SECONDS) win_len = data[WIN_W-1:0];
      else if (idx == CFG_TRIP_FAILURES) trip_lvl = data[TRIP_W-1:0];
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now);
      longint unsigned w;
      longint unsigned gap;
      int unsigned     adv;
      int unsigned     idx;
      int unsigned     i;
      verdict_t        v;
      w = 64'(win_len);
      // bring the window up to date
      if (now < win_start) wipe(now);
      gap = {32'd0, now} - {32'd0, win_start};
      if (gap >= w) begin
        if (gap >= 3 * w || gap >= RING) begin
          wipe(now);
        end else begin
          adv = 32'(gap - w + 1);
          for (i = 0; i < adv; i++) begin
            idx = (oldest + i) % RING;
            win_fail -= 22'(fail_cnt[idx]);
            win_succ -= 22'(succ_cnt[idx]);
            fail_cnt[idx] = '0;
            succ_cnt[idx] = '0;
          end
          oldest = (oldest + adv) % RING;
          win_start += adv;
        end
      end
      // mode step, skipped while the open hold lasts
      if (!(brk_mode == MODE_OPEN &&
            (now < last_upd || {32'd0, now - last_upd} <= w))) begin
        last_upd = now;
        cur = (oldest + (now - win_start)) % RING;
        if (brk_mode == MODE_CLOSED) begin
          if (win_fail >= trip_lvl) enter_mode(now, MODE_OPEN);
        end else if (brk_mode == MODE_HALF) begin
          if (win_fail > HALF_FAIL_LIMIT) enter_mode(now, MODE_OPEN);
          else if (win_succ > HALF_SUCC_LIMIT) enter_mode(now, MODE_CLOSED);
        end else begin
          enter_mode(now, MODE_HALF);
        end
      end
      // reports land in the current bucket, saturating
      if (req == REQ_SUCCESS) begin
        if (succ_cnt[cur] != BUCKET_MAX) begin
          succ_cnt[cur] += 16'd1;
          win_succ += 22'd1;
        end
      end else if (req == REQ_FAILURE) begin
        if (fail_cnt[cur] != BUCKET_MAX) begin
          fail_cnt[cur] += 16'd1;
          win_fail += 22'd1;
        end
      end
      v.allowed = (brk_mode != MODE_OPEN);
      v.mode    = brk_mode;
      verdicts.push_back(v);
      noted++;
    endfunction

    function void check_result(logic got_allowed, logic [MODE_W-1:0] got_mode);
      verdict_t want;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, allowed %0b mode %0d",
                 $time, got_allowed, got_mode);
        return;
      end
      want = verdicts.pop_front();
      mode_hits[want.mode]++;
      if (got_allowed !== want.allowed) begin
        errors++;
        $display("%0t: allowed mismatch, expected %0b, actual %0b",
                 $time, want.allowed, got_allowed);
      end
      if (got_mode !== want.mode) begin
        errors++;
        $display("%0t: mode mismatch, expected %0d, actual %0d", $time, want.mode, got_mode);
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction

    function void report_leftovers();
      if (verdicts.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived", $time, verdicts.size());
      end
    endfunction
  endclass

  // every input known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      req_type = REQ_CHECK;
  logic [TIME_W-1:0]     now_seconds = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  allowed;
  logic [MODE_W-1:0]     mode;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW_SECONDS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // no gaps on either side while calm is set
  logic                  calm = 1'b0;
  int unsigned           stall_left = 0;
  int unsigned           n_configs = 0;
  breaker_tracker        sb;

  sliding_window_circuit_breaker_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .now_seconds (now_seconds),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .allowed     (allowed),
    .mode        (mode),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // next request time: mostly the same second or the next, sometimes
  // far enough to expire buckets, now and then a jump or a step back
  function automatic logic [TIME_W-1:0] next_second(input logic [TIME_W-1:0] t,
                                                    input logic [WIN_W-1:0] w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return t;
    if (r < 80) return t + 1;
    if (r < 90) return t + $urandom_range(2, w + 1);
    if (r < 96) return t + $urandom_range(w, 3 * w + 2);
    if (r < 98) return t + $urandom_range(64, 5000);
    if (r < 99) return $urandom();
    return t - $urandom_range(1, 20);
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(input int unsigned mix);
    int unsigned r;
    int unsigned lim_chk;
    int unsigned lim_succ;
    int unsigned lim_fail;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FAILS: begin
        lim_chk = 10; lim_succ = 20; lim_fail = 97;
      end
      MIX_SUCCESS: begin
        lim_chk = 10; lim_succ = 90; lim_fail = 95;
      end
      MIX_CHECKS: begin
        lim_chk = 80; lim_succ = 88; lim_fail = 96;
      end
      default: begin
        lim_chk = 30; lim_succ = 60; lim_fail = 95;
      end
    endcase
    if (r < lim_chk) return REQ_CHECK;
    if (r < lim_succ) return REQ_SUCCESS;
    if (r < lim_fail) return REQ_FAILURE;
    return REQ_UNUSED;
  endfunction

  // one request, then a random pause of the sender
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] now);
    int unsigned gap;
    in_valid    <= 1'b1;
    req_type    <= req;
    now_seconds <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, now);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every promised result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // both registers, back to back; only called with the block idle
  task automatic configure(input logic [WIN_W-1:0] win, input logic [TRIP_W-1:0] trip);
    logic [CFG_DATA_W-1:0] win_word;
    // bits above the window field are junk the block must drop
    win_word = CFG_DATA_W'($urandom());
    win_word[WIN_W-1:0] = win;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW_SECONDS;
    cfg_data  <= win_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(CFG_WINDOW_SECONDS, win_word);
    cfg_index <= CFG_TRIP_FAILURES;
    cfg_data  <= trip;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(CFG_TRIP_FAILURES, trip);
    cfg_valid <= 1'b0;
    n_configs++;
  endtask

  // result side: random stall stretches, none while calm
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every accepted result goes against the oldest verdict
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(allowed, mode);
  end

  initial begin
    logic [TIME_W-1:0] t;
    logic [WIN_W-1:0]  win_now;
    logic [TRIP_W-1:0] trip_now;
    int unsigned       phase;
    int unsigned       remaining;
    int unsigned       burst;
    int unsigned       mix;
    int unsigned       k;
    int unsigned       n;

    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: zero time, then the top of the time range
    issue_request(REQ_CHECK, 32'd0);
    issue_request(REQ_FAILURE, 32'hFFFF_FFFF);
    issue_request(REQ_UNUSED, 32'hFFFF_FFFF);
    wait_drained();

    // short window, trip on two failures
    configure(6'd4, 16'd2);
    issue_request(REQ_FAILURE, 32'd100);
    issue_request(REQ_FAILURE, 32'd101);
    // closed trips to open
    issue_request(REQ_CHECK, 32'd101);
    // open hold: the report still lands in a bucket
    issue_request(REQ_SUCCESS, 32'd102);
    // last second of the hold, while the oldest bucket expires
    issue_request(REQ_CHECK, 32'd105);
    // hold over: half-open, then more than five failures reopen it
    issue_request(REQ_FAILURE, 32'd106);
    repeat (5) issue_request(REQ_FAILURE, 32'd106);
    issue_request(REQ_CHECK, 32'd107);
    // earlier time while open
    issue_request(REQ_CHECK, 32'd50);
    // time going back to zero, then big jumps
    issue_request(REQ_SUCCESS, 32'd0);
    issue_request(REQ_FAILURE, 32'h8000_0000);
    issue_request(REQ_UNUSED, 32'h8000_0001);
    issue_request(REQ_CHECK, 32'hFFFF_FFFF);
    wait_drained();

    // random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin win_now = 6'd1;  trip_now = 16'd1; end
        1: begin win_now = 6'd63; trip_now = 16'hFFFF; end
        // zero window clears on every request
        2: begin win_now = 6'd0;  trip_now = 16'd3; end
        3: begin win_now = 6'd63; trip_now = 16'd1; end
        4: begin win_now = 6'd5;  trip_now = 16'd8; end
        5: begin
          win_now  = WIN_W'($urandom_range(2, 30));
          trip_now = TRIP_W'($urandom_range(2, 12));
        end
        6: begin
          win_now  = WIN_W'($urandom_range(2, 62));
          trip_now = TRIP_W'($urandom_range(1, 40));
        end
        default: begin win_now = WINDOW_SECONDS_RST; trip_now = TRIP_FAILURES_RST; end
      endcase
      configure(win_now, trip_now);
      // one phase starts just below the time wrap
      t = (phase == 6) ? 32'hFFFF_FF80 : TIME_W'($urandom_range(0, 100000));
      remaining = PHASE_ITEMS;
      while (remaining != 0) begin
        burst = $urandom_range(5, 40);
        mix   = $urandom_range(MIX_EVEN, MIX_CHECKS);
        calm  <= ($urandom_range(0, 4) == 0);
        for (k = 0; k < burst && remaining != 0; k++) begin
          t = next_second(t, win_now);
          issue_request(pick_request(mix), t);
          remaining--;
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    // let the last results come back, with a bound
    in_valid <= 1'b0;
    calm     <= 1'b0;
    for (n = 0; n < 20000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (200) @(posedge clk);
    sb.report_leftovers();

    $display("run: %0d requests under %0d register settings, windows 0 to 63",
             sb.noted, n_configs);
    $display("verdicts: %0d closed, %0d open, %0d half-open",
             sb.mode_hits[MODE_CLOSED], sb.mode_hits[MODE_OPEN], sb.mode_hits[MODE_HALF]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #30000000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule
